/* rtl/touch_sample_calibrate_macros.svh */
// Assertion macros for the touch sample calibration block.
// Included by the top level; no other dependencies.
`ifndef TOUCH_SAMPLE_CALIBRATE_MACROS_SVH
`define TOUCH_SAMPLE_CALIBRATE_MACROS_SVH

// Implication checked in the same cycle, disabled during reset
`define TSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("touch_sample_calibrate: assertion failed");

// Implication checked in the next cycle, disabled during reset
`define TSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("touch_sample_calibrate: assertion failed");

`endif

/* rtl/tsc_pkg.sv */
// Shared types and constants for the touch sample calibration block.
// No dependencies.
package tsc_pkg;

	localparam int RAW_W     = 12;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_RAW_X_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_X_RIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_Y_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_Y_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_MIN = 3'd4;

	localparam logic [RAW_W-1:0] RST_RAW_X_LEFT   = 12'd200;
	localparam logic [RAW_W-1:0] RST_RAW_X_RIGHT  = 12'd3900;
	localparam logic [RAW_W-1:0] RST_RAW_Y_TOP    = 12'd200;
	localparam logic [RAW_W-1:0] RST_RAW_Y_BOTTOM = 12'd3700;
	localparam logic [RAW_W-1:0] RST_PRESSURE_MIN = 12'd400;

	typedef struct packed {
		logic [RAW_W-1:0] first_x;
		logic [RAW_W-1:0] first_y;
		logic [RAW_W-1:0] first_pressure;
		logic [RAW_W-1:0] second_x;
		logic [RAW_W-1:0] second_y;
		logic [RAW_W-1:0] second_pressure;
	} sample_t;

	typedef struct packed {
		logic       pressed;
		logic [8:0] screen_x;
		logic [7:0] screen_y;
	} result_t;

	// Per-item division flags: result negative, result at or past the screen edge
	typedef struct packed {
		logic neg;
		logic sat;
	} flag_t;

endpackage

/* rtl/touch_sample_calibrate.sv */
// Top level of the touch sample calibration block: configuration registers,
// pressure check, averaging and the pipeline control. Depends on tsc_pkg,
// tsc_axis, tsc_div_step and touch_sample_calibrate_macros.svh.

// The block takes one pair of touch samples on every clock cycle; busy stays
// low. Each transaction yields one result, shown on result for a single cycle
// with result_valid high. A sample passes in turn through the sample register,
// the two axis registers, the QW divider steps and the result register, where
// QW = clog2(max(SCREEN_WIDTH, SCREEN_HEIGHT)). The restoring divider
// resolves one quotient bit per pipeline stage. The receiver cannot stall, so
// results must be captured when presented. Write calibration registers only
// when no transaction is in flight.
`include "touch_sample_calibrate_macros.svh"

module touch_sample_calibrate #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tsc_pkg::sample_t              sample,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsc_pkg::RAW_W-1:0]     cfg_data,
	output logic                          result_valid,
	output tsc_pkg::result_t              result
);

	localparam int RW       = tsc_pkg::RAW_W;
	localparam int SIZE_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int QW       = $clog2(SIZE_MAX);
	localparam int DEPTH    = QW + 3;
	localparam int LAT      = QW + 4;

	logic [RW-1:0] raw_x_left_q;
	logic [RW-1:0] raw_x_right_q;
	logic [RW-1:0] raw_y_top_q;
	logic [RW-1:0] raw_y_bottom_q;
	logic [RW-1:0] pressure_min_q;

	logic             accept;
	tsc_pkg::sample_t sample_s1;
	logic [DEPTH-1:0] valid_sn;
	logic [DEPTH-2:0] pressed_sn;

	logic          pressed_c;
	logic [RW:0]   sum_x_c;
	logic [RW:0]   sum_y_c;
	logic [QW-1:0] pos_x;
	logic [QW-1:0] pos_y;

	logic             result_valid_q;
	tsc_pkg::result_t result_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_x_left_q   <= tsc_pkg::RST_RAW_X_LEFT;
			raw_x_right_q  <= tsc_pkg::RST_RAW_X_RIGHT;
			raw_y_top_q    <= tsc_pkg::RST_RAW_Y_TOP;
			raw_y_bottom_q <= tsc_pkg::RST_RAW_Y_BOTTOM;
			pressure_min_q <= tsc_pkg::RST_PRESSURE_MIN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tsc_pkg::REG_RAW_X_LEFT:   raw_x_left_q   <= cfg_data;
				tsc_pkg::REG_RAW_X_RIGHT:  raw_x_right_q  <= cfg_data;
				tsc_pkg::REG_RAW_Y_TOP:    raw_y_top_q    <= cfg_data;
				tsc_pkg::REG_RAW_Y_BOTTOM: raw_y_bottom_q <= cfg_data;
				tsc_pkg::REG_PRESSURE_MIN: pressure_min_q <= cfg_data;
				default: ; // drop writes to unknown indexes
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
	end

	always_comb begin
		pressed_c = (sample_s1.first_pressure >= pressure_min_q) &&
			(sample_s1.second_pressure >= pressure_min_q);
		sum_x_c = {1'b0, sample_s1.first_x} + {1'b0, sample_s1.second_x};
		sum_y_c = {1'b0, sample_s1.first_y} + {1'b0, sample_s1.second_y};
	end

	tsc_axis #(
		.SIZE (SCREEN_WIDTH),
		.QW   (QW)
	) u_axis_x (
		.clk (clk),
		.avg (sum_x_c[RW:1]),
		.lo  (raw_x_left_q),
		.hi  (raw_x_right_q),
		.pos (pos_x)
	);

	tsc_axis #(
		.SIZE (SCREEN_HEIGHT),
		.QW   (QW)
	) u_axis_y (
		.clk (clk),
		.avg (sum_y_c[RW:1]),
		.lo  (raw_y_top_q),
		.hi  (raw_y_bottom_q),
		.pos (pos_y)
	);

	// Valid bits advance alongside the axis pipelines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= '0;
		end else begin
			valid_sn <= {valid_sn[DEPTH-2:0], accept};
		end
	end

	// Pressed flag enters one stage later, beside the first axis register
	always_ff @(posedge clk) begin
		pressed_sn <= {pressed_sn[DEPTH-3:0], pressed_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_sn[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		result_q.pressed  <= pressed_sn[DEPTH-2];
		result_q.screen_x <= pressed_sn[DEPTH-2] ? 9'(pos_x) : 9'd0;
		result_q.screen_y <= pressed_sn[DEPTH-2] ? 8'(pos_y) : 8'd0;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`TSC_ASSERT_IMP(a_start_to_result, clk, arst_n, start && !busy, ##LAT result_valid)
	`TSC_ASSERT_IMP(a_result_from_start, clk, arst_n, result_valid,
		$past(start && !busy, LAT))
	`TSC_ASSERT_IMP(a_released_zero, clk, arst_n, result_valid && !result.pressed,
		result.screen_x == 9'd0 && result.screen_y == 8'd0)
	`TSC_ASSERT_NXT(a_strobe_follows_pipe, clk, arst_n, valid_sn[DEPTH-1], result_valid)

endmodule

/* rtl/tsc_div_step.sv */
// One registered step of the restoring divider: resolves one quotient bit.
// Depends on tsc_pkg.
module tsc_div_step #(
	parameter int NW = 21,
	parameter int QW = 9,
	parameter int K  = 0
) (
	input  logic                     clk,
	input  logic [NW-1:0]            rem_in,
	input  logic [tsc_pkg::RAW_W-1:0] den_in,
	input  logic [QW-1:0]            q_in,
	input  tsc_pkg::flag_t           flag_in,
	output logic [NW-1:0]            rem_out,
	output logic [tsc_pkg::RAW_W-1:0] den_out,
	output logic [QW-1:0]            q_out,
	output tsc_pkg::flag_t           flag_out
);

	logic [NW-1:0] trial;
	logic          ge;
	logic [NW-1:0] rem_next;
	logic [QW-1:0] q_next;

	logic [NW-1:0]             rem_s1;
	logic [tsc_pkg::RAW_W-1:0] den_s1;
	logic [QW-1:0]             q_s1;
	tsc_pkg::flag_t            flag_s1;

	always_comb begin
		trial    = NW'(den_in) << K;
		ge       = (rem_in >= trial);
		rem_next = ge ? (rem_in - trial) : rem_in;
		q_next   = q_in;
		q_next[K] = ge;
	end

	always_ff @(posedge clk) begin
		rem_s1  <= rem_next;
		den_s1  <= den_in;
		q_s1    <= q_next;
		flag_s1 <= flag_in;
	end

	assign rem_out  = rem_s1;
	assign den_out  = den_s1;
	assign q_out    = q_s1;
	assign flag_out = flag_s1;

endmodule

/* rtl/tsc_axis.sv */
// Maps one averaged raw reading onto a clamped screen position.
// Depends on tsc_pkg and tsc_div_step.
module tsc_axis #(
	parameter int SIZE = 320,
	parameter int QW   = 9
) (
	input  logic                      clk,
	input  logic [tsc_pkg::RAW_W-1:0] avg,
	input  logic [tsc_pkg::RAW_W-1:0] lo,
	input  logic [tsc_pkg::RAW_W-1:0] hi,
	output logic [QW-1:0]             pos
);

	localparam int RW = tsc_pkg::RAW_W;
	localparam int NW = RW + QW;
	localparam logic [QW-1:0] POS_MAX = QW'(SIZE - 1);

	logic [RW:0]   diff_c;
	logic [RW:0]   span_raw_c;
	logic [RW:0]   span_c;
	logic [RW:0]   diff_neg_c;
	logic [RW:0]   span_neg_c;
	logic [RW-1:0] mag_a_c;
	logic [RW-1:0] mag_d_c;
	tsc_pkg::flag_t flag_c;

	logic [RW-1:0]  mag_a_s2;
	logic [RW-1:0]  mag_d_s2;
	tsc_pkg::flag_t flag_s2;

	logic [NW-1:0]  num_s3;
	logic [RW-1:0]  den_s3;
	tsc_pkg::flag_t flag_s3;

	logic [NW-1:0]  rem_w  [0:QW];
	logic [RW-1:0]  den_w  [0:QW];
	logic [QW-1:0]  q_w    [0:QW];
	tsc_pkg::flag_t flag_w [0:QW];

	always_comb begin
		diff_c     = {1'b0, avg} - {1'b0, lo};
		span_raw_c = {1'b0, hi} - {1'b0, lo};
		// equal calibration points count as a span of one
		span_c     = (span_raw_c == '0) ? (RW+1)'(1) : span_raw_c;
		diff_neg_c = -diff_c;
		span_neg_c = -span_c;
		mag_a_c    = diff_c[RW] ? diff_neg_c[RW-1:0] : diff_c[RW-1:0];
		mag_d_c    = span_c[RW] ? span_neg_c[RW-1:0] : span_c[RW-1:0];
		flag_c.neg = diff_c[RW] ^ span_c[RW];
		// |a|*(SIZE-1)/|d| reaches SIZE-1 exactly when |a| >= |d|
		flag_c.sat = (mag_a_c >= mag_d_c);
	end

	always_ff @(posedge clk) begin
		mag_a_s2 <= mag_a_c;
		mag_d_s2 <= mag_d_c;
		flag_s2  <= flag_c;
	end

	always_ff @(posedge clk) begin
		num_s3  <= NW'(mag_a_s2) * NW'(POS_MAX);
		den_s3  <= mag_d_s2;
		flag_s3 <= flag_s2;
	end

	assign rem_w[0]  = num_s3;
	assign den_w[0]  = den_s3;
	assign q_w[0]    = '0;
	assign flag_w[0] = flag_s3;

	// Unsaturated quotients stay below SIZE-1, so QW bits cover them
	for (genvar i = 0; i < QW; i++) begin : g_div
		tsc_div_step #(
			.NW (NW),
			.QW (QW),
			.K  (QW - 1 - i)
		) u_step (
			.clk      (clk),
			.rem_in   (rem_w[i]),
			.den_in   (den_w[i]),
			.q_in     (q_w[i]),
			.flag_in  (flag_w[i]),
			.rem_out  (rem_w[i+1]),
			.den_out  (den_w[i+1]),
			.q_out    (q_w[i+1]),
			.flag_out (flag_w[i+1])
		);
	end

	always_comb begin
		if (flag_w[QW].neg) begin
			pos = '0;
		end else if (flag_w[QW].sat) begin
			pos = POS_MAX;
		end else begin
			pos = q_w[QW];
		end
	end

endmodule

/* verif/tb.sv */
// Self-checking testbench for touch_sample_calibrate: directed and random touch samples
// against an in-bench prediction of the calibrated screen position.
// Depends on tsc_pkg and the touch_sample_calibrate RTL.
module tb;
	import tsc_pkg::*;

	localparam int DISP_COLS      = 320;
	localparam int DISP_ROWS      = 240;
	localparam int LATENCY_CYCLES = 13;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 190;
	localparam int MAX_GAP        = 18;
	localparam int REG_COUNT      = 5;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	sample_t              sample;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RAW_W-1:0]     cfg_data;
	logic                 result_valid;
	result_t              result;

	// Calibration as the block should hold it
	logic [RAW_W-1:0] cal_x_left;
	logic [RAW_W-1:0] cal_x_right;
	logic [RAW_W-1:0] cal_y_top;
	logic [RAW_W-1:0] cal_y_bottom;
	logic [RAW_W-1:0] cal_pressure_min;

	result_t pending_results[$];
	int      gap_limit;
	int      error_count;
	int      items_sent;
	int      results_checked;
	int      touches_seen;
	int      register_writes;
	int      cycle_count;

	touch_sample_calibrate #(
		.SCREEN_WIDTH (DISP_COLS),
		.SCREEN_HEIGHT(DISP_ROWS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.sample      (sample),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result      (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int scale_to_screen(int avg, int lo, int hi, int size);
		int span;
		int pos;
		span = hi - lo;
		// equal calibration points count as a span of one
		if (span == 0) span = 1;
		pos = (avg - lo) * (size - 1) / span;
		if (pos < 0) pos = 0;
		if (pos > size - 1) pos = size - 1;
		return pos;
	endfunction

	function automatic result_t calibrate_sample(sample_t s);
		result_t r;
		int      avg_x;
		int      avg_y;
		r = '0;
		if (s.first_pressure >= cal_pressure_min && s.second_pressure >= cal_pressure_min) begin
			avg_x = (int'(s.first_x) + int'(s.second_x)) >> 1;
			avg_y = (int'(s.first_y) + int'(s.second_y)) >> 1;
			r.pressed  = 1'b1;
			r.screen_x = 9'(scale_to_screen(avg_x, int'(cal_x_left), int'(cal_x_right), DISP_COLS));
			r.screen_y = 8'(scale_to_screen(avg_y, int'(cal_y_top), int'(cal_y_bottom), DISP_ROWS));
		end
		return r;
	endfunction

	function automatic sample_t touch(int x1, int y1, int p1, int x2, int y2, int p2);
		sample_t s;
		s.first_x         = RAW_W'(x1);
		s.first_y         = RAW_W'(y1);
		s.first_pressure  = RAW_W'(p1);
		s.second_x        = RAW_W'(x2);
		s.second_y        = RAW_W'(y2);
		s.second_pressure = RAW_W'(p2);
		return s;
	endfunction

	function automatic logic [RAW_W-1:0] jitter_raw(int center);
		int v;
		v = center + int'($urandom_range(0, 64)) - 32;
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return RAW_W'(v);
	endfunction

	function automatic logic [RAW_W-1:0] pick_calibration();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	// Mostly plausible touches around the calibrated span; the rest noise or a light touch
	function automatic sample_t random_touch();
		sample_t s;
		int      kind;
		int      cx;
		int      cy;
		kind = $urandom_range(0, 19);
		s = sample_t'({$urandom, $urandom, 8'($urandom)});
		if (kind < 3) return s;
		if ($urandom_range(0, 3) == 0) begin
			cx = $urandom_range(0, 4095);
			cy = $urandom_range(0, 4095);
		end else begin
			cx = $urandom_range(int'(cal_x_left), int'(cal_x_right));
			cy = $urandom_range(int'(cal_y_top), int'(cal_y_bottom));
		end
		s.first_x         = jitter_raw(cx);
		s.second_x        = jitter_raw(cx);
		s.first_y         = jitter_raw(cy);
		s.second_y        = jitter_raw(cy);
		s.first_pressure  = RAW_W'($urandom_range(int'(cal_pressure_min), 4095));
		s.second_pressure = RAW_W'($urandom_range(int'(cal_pressure_min), 4095));
		if (kind < 5 && cal_pressure_min != 0) begin
			if (kind == 3) s.first_pressure = cal_pressure_min - 1'b1;
			else s.second_pressure = RAW_W'($urandom_range(0, int'(cal_pressure_min) - 1));
		end
		return s;
	endfunction

	task automatic send_touch(input sample_t s);
		int gap;
		gap = $urandom_range(0, gap_limit);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		sample <= s;
		do @(posedge clk); while (busy);
		pending_results.push_back(calibrate_sample(s));
		items_sent++;
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [RAW_W-1:0] value);
		int gap;
		// cfg_valid returns low between transactions
		gap = $urandom_range(1, gap_limit + 1);
		repeat (gap) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RAW_X_LEFT:   cal_x_left       = value;
			REG_RAW_X_RIGHT:  cal_x_right      = value;
			REG_RAW_Y_TOP:    cal_y_top        = value;
			REG_RAW_Y_BOTTOM: cal_y_bottom     = value;
			REG_PRESSURE_MIN: cal_pressure_min = value;
			default: ;
		endcase
		register_writes++;
	endtask

	task automatic write_calibration(input int xl, input int xr, input int yt, input int yb,
		input int pmin);
		wait_for_results();
		write_register(REG_RAW_X_LEFT, RAW_W'(xl));
		write_register(REG_RAW_X_RIGHT, RAW_W'(xr));
		write_register(REG_RAW_Y_TOP, RAW_W'(yt));
		write_register(REG_RAW_Y_BOTTOM, RAW_W'(yb));
		write_register(REG_PRESSURE_MIN, RAW_W'(pmin));
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$error("result with no sample outstanding: pressed %0d x %0d y %0d",
					result.pressed, result.screen_x, result.screen_y);
				error_count++;
			end else begin
				result_t want;
				want = pending_results.pop_front();
				if (result.pressed !== want.pressed) begin
					$error("pressed mismatch: expected %0d, actual %0d", want.pressed, result.pressed);
					error_count++;
				end
				if (result.screen_x !== want.screen_x) begin
					$error("screen_x mismatch: expected %0d, actual %0d", want.screen_x,
						result.screen_x);
					error_count++;
				end
				if (result.screen_y !== want.screen_y) begin
					$error("screen_y mismatch: expected %0d, actual %0d", want.screen_y,
						result.screen_y);
					error_count++;
				end
				if (want.pressed) touches_seen++;
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Reset calibration: edges, clamping, thresholds and rounding
	task automatic test_reset_defaults();
		gap_limit = MAX_GAP;
		send_touch(touch(0, 0, 0, 0, 0, 0));
		send_touch(touch(4095, 4095, 4095, 4095, 4095, 4095));
		send_touch(touch(2000, 1500, 400, 2000, 1500, 400));
		send_touch(touch(2000, 1500, 399, 2000, 1500, 4095));
		send_touch(touch(2000, 1500, 4095, 2000, 1500, 399));
		send_touch(touch(200, 200, 1000, 200, 200, 1000));
		send_touch(touch(3900, 3700, 1000, 3900, 3700, 1000));
		send_touch(touch(213, 216, 1000, 214, 217, 1000));
		send_touch(touch(0, 4095, 1000, 100, 4000, 1000));
	endtask

	// Equal, reversed and full-range calibration; extreme thresholds
	task automatic test_calibration_edges();
		gap_limit = 2;
		write_calibration(1000, 1000, 500, 500, 0);
		send_touch(touch(999, 499, 0, 999, 499, 0));
		send_touch(touch(1000, 500, 0, 1000, 500, 0));
		send_touch(touch(1001, 501, 0, 1001, 501, 0));
		send_touch(touch(1002, 502, 0, 1002, 502, 0));
		write_calibration(4095, 0, 4095, 0, 4095);
		send_touch(touch(0, 0, 4095, 0, 0, 4095));
		send_touch(touch(3000, 1000, 4095, 3001, 1001, 4095));
		send_touch(touch(3000, 1000, 4094, 3001, 1001, 4095));
		write_calibration(0, 4095, 0, 4095, 1);
		send_touch(touch(4095, 4095, 1, 4094, 4094, 1));
		send_touch(touch(2048, 2047, 0, 2048, 2047, 2));
	endtask

	// Writes to indexes past the last register must leave the calibration alone
	task automatic test_unknown_index();
		wait_for_results();
		for (int i = int'(REG_PRESSURE_MIN) + 1; i < (1 << CFG_IDX_W); i++)
			write_register(CFG_IDX_W'(i), RAW_W'($urandom));
		send_touch(touch(1234, 2345, 100, 3456, 567, 200));
		send_touch(touch(4095, 0, 4095, 0, 4095, 4095));
	endtask

	task automatic test_random_traffic();
		int cal[REG_COUNT];
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			gap_limit = $urandom_range(0, MAX_GAP);
			for (int r = 0; r < REG_COUNT; r++) cal[r] = pick_calibration();
			case (phase)
				0: cal = '{0, 4095, 0, 4095, 0};
				1: cal = '{4095, 0, 4095, 0, 4095};
				2: begin
					cal[1] = cal[0];
					cal[3] = cal[2];
				end
				3: cal = '{200, 3900, 200, 3700, 400};
				default: ;
			endcase
			write_calibration(cal[0], cal[1], cal[2], cal[3], cal[4]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// switch between back-to-back bursts, short gaps and long gaps
				if (n % 25 == 0) begin
					case ($urandom_range(0, 2))
						0: gap_limit = 0;
						1: gap_limit = 3;
						default: gap_limit = MAX_GAP;
					endcase
				end
				send_touch(random_touch());
			end
		end
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		sample      = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		gap_limit   = 0;
		error_count = 0;
		cycle_count = 0;
		cal_x_left       = RST_RAW_X_LEFT;
		cal_x_right      = RST_RAW_X_RIGHT;
		cal_y_top        = RST_RAW_Y_TOP;
		cal_y_bottom     = RST_RAW_Y_BOTTOM;
		cal_pressure_min = RST_PRESSURE_MIN;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_calibration_edges();
		test_unknown_index();
		test_random_traffic();

		wait_for_results();
		repeat (2 * LATENCY_CYCLES) @(posedge clk);
		$display("Covered %0d samples (%0d touches) over %0d register writes; %0d results checked",
			items_sent, touches_seen, register_writes, results_checked);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/tsc_pkg.sv
rtl/tsc_div_step.sv
rtl/tsc_axis.sv
rtl/touch_sample_calibrate.sv
verif/tb.sv
